// File: rtl/ipe_pkg.sv
package ipe_pkg;

	// Fixed widths of the item fields.
	localparam int DATA_BITS = 64;
	localparam int OP_BITS   = 3;
	localparam int ERR_BITS  = 2;

	// Defaults for the top-level parameters.
	localparam int WORD_BITS_DEF     = 64;
	localparam int FRACTION_BITS_DEF = 32;

	// Operator codes carried by an input item; codes above OP_DIV are "other".
	localparam logic [OP_BITS-1:0] OP_ADD = 3'd0;
	localparam logic [OP_BITS-1:0] OP_SUB = 3'd1;
	localparam logic [OP_BITS-1:0] OP_MUL = 3'd2;
	localparam logic [OP_BITS-1:0] OP_DIV = 3'd3;

	// Pending operation between the running sum and the next term.
	localparam logic [1:0] SUM_ADD  = 2'd0;
	localparam logic [1:0] SUM_SUB  = 2'd1;
	localparam logic [1:0] SUM_DROP = 2'd2;

	// Error codes, ordered by priority.
	localparam logic [ERR_BITS-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_BITS-1:0] ERR_OVF  = 2'd1;
	localparam logic [ERR_BITS-1:0] ERR_DIV0 = 2'd2;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PREP = 8'b0000_0010,
		ST_MUL  = 8'b0000_0100,
		ST_DIV  = 8'b0000_1000,
		ST_RND  = 8'b0001_0000,
		ST_PACK = 8'b0010_0000,
		ST_COMB = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} state_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic accept;
		logic pending;
		logic divides;
		logic div_zero;
		logic last;
		logic hold_term;
		logic out_free;
	} status_t;

	// Step strobes driven by the sequencer.
	typedef struct packed {
		logic idle;
		logic prep;
		logic mul_step;
		logic div_step;
		logic rnd_step;
		logic pack;
		logic comb;
		logic emit;
	} ctrl_t;

	function automatic logic [ERR_BITS-1:0] err_max(input logic [ERR_BITS-1:0] a,
		input logic [ERR_BITS-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

// File: rtl/ipe_addsub.sv
// The shared adder of the block: accumulates in multiply, trial-subtracts in
// divide, rounds in packing and forms the running sum.
module ipe_addsub #(
	parameter int WIDTH = ipe_pkg::WORD_BITS_DEF + 1
) (
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic             sub,
	output logic [WIDTH-1:0] sum
);

	assign sum = a + (sub ? ~b : b) + WIDTH'(sub);

endmodule

// File: rtl/ipe_seq.sv
// Sequencer: steps one transaction through prepare, iterate, pack and combine.
module ipe_seq #(
	parameter int WORD_BITS     = ipe_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = ipe_pkg::FRACTION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ipe_pkg::status_t status,
	output ipe_pkg::ctrl_t   ctrl
);

	localparam int N  = WORD_BITS + FRACTION_BITS;
	localparam int CW = $clog2(N + 1);

	ipe_pkg::state_t state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ipe_pkg::ST_IDLE: begin
				if (status.accept) state_d = ipe_pkg::ST_PREP;
			end
			ipe_pkg::ST_PREP: begin
				cnt_d = '0;
				if (!status.pending || (status.divides && status.div_zero))
					state_d = ipe_pkg::ST_COMB;
				else if (status.divides)
					state_d = ipe_pkg::ST_DIV;
				else
					state_d = ipe_pkg::ST_MUL;
			end
			ipe_pkg::ST_MUL: begin
				if (cnt_q == CW'(WORD_BITS - 1)) state_d = ipe_pkg::ST_PACK;
				else cnt_d = cnt_q + CW'(1);
			end
			ipe_pkg::ST_DIV: begin
				if (cnt_q == CW'(N - 1)) state_d = ipe_pkg::ST_RND;
				else cnt_d = cnt_q + CW'(1);
			end
			ipe_pkg::ST_RND: state_d = ipe_pkg::ST_PACK;
			ipe_pkg::ST_PACK: state_d = ipe_pkg::ST_COMB;
			ipe_pkg::ST_COMB: begin
				if (!status.hold_term && status.last) state_d = ipe_pkg::ST_EMIT;
				else state_d = ipe_pkg::ST_IDLE;
			end
			ipe_pkg::ST_EMIT: begin
				if (status.out_free) state_d = ipe_pkg::ST_IDLE;
			end
			default: state_d = ipe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipe_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign ctrl.idle     = (state_q == ipe_pkg::ST_IDLE);
	assign ctrl.prep     = (state_q == ipe_pkg::ST_PREP);
	assign ctrl.mul_step = (state_q == ipe_pkg::ST_MUL);
	assign ctrl.div_step = (state_q == ipe_pkg::ST_DIV);
	assign ctrl.rnd_step = (state_q == ipe_pkg::ST_RND);
	assign ctrl.pack     = (state_q == ipe_pkg::ST_PACK);
	assign ctrl.comb     = (state_q == ipe_pkg::ST_COMB);
	assign ctrl.emit     = (state_q == ipe_pkg::ST_EMIT);

endmodule

// File: rtl/infix_precedence_evaluator.sv
// Each item passes through the sequencer states in order: one with no pending factor, or with a
// zero divisor, goes through prepare and combine; a multiply item steps the adder once per word
// bit and then packs; a divide item steps once per numerator bit, rounds and packs. After combine
// a last item offers its result and waits while the output is stalled; the defaults give Q32.32.
// A new item is accepted only in the idle state, so items never overlap on the single shared adder.
// Reset (arst_n low, asynchronous) clears the expression state, the sequencer and the output valid.
module infix_precedence_evaluator #(
	parameter int WORD_BITS     = ipe_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = ipe_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ipe_pkg::DATA_BITS-1:0] operand_value,
	input  logic        [ipe_pkg::OP_BITS-1:0]   operator_code,
	input  logic                                 first_item,
	input  logic                                 last_item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ipe_pkg::DATA_BITS-1:0] result_value,
	output logic        [ipe_pkg::ERR_BITS-1:0]  error_code
);

	// W is the internal word, N the divide numerator (magnitude shifted up by the
	// fraction), XW a vector wide enough for any unpacked product or quotient.
	localparam int W      = WORD_BITS;
	localparam int F      = FRACTION_BITS;
	localparam int N      = W + F;
	localparam int XW     = 2 * W + F;
	localparam int AW     = W + 1;
	localparam bit RB_EN  = (F > 0);
	localparam int RB_IDX = (F > 0) ? F - 1 : 0;
	localparam int TOP_W  = ipe_pkg::DATA_BITS - W + 1;

	localparam logic [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};

	ipe_pkg::status_t status;
	ipe_pkg::ctrl_t   ctrl;

	// Expression state: running sum, its pending operation, and the product term.
	logic signed [W-1:0]          sum_q;
	logic [1:0]                   sum_op_q;
	logic                         started_q;
	logic signed [W-1:0]          term_q;
	logic                         pending_q;
	logic                         divides_q;
	logic [ipe_pkg::ERR_BITS-1:0] err_q;

	// The accepted item.
	logic signed [W-1:0]         x_q;
	logic [ipe_pkg::OP_BITS-1:0] op_q;
	logic                        last_q;

	// Iteration registers. In a multiply, acc_q is the upper product half and
	// the low W bits of sh_q take the multiplier in and the lower half out.
	// In a divide, acc_q is the partial remainder and sh_q shifts numerator
	// bits out at the top while quotient bits enter at the bottom.
	logic [W-1:0] ma_q;
	logic [W-1:0] acc_q;
	logic [N-1:0] sh_q;
	logic         neg_q;
	logic         rb_q;
	logic [W-1:0] tres_q;

	logic                         out_valid_q;
	logic signed [ipe_pkg::DATA_BITS-1:0] result_q;
	logic [ipe_pkg::ERR_BITS-1:0] err_out_q;

	logic accept;
	logic out_free;

	// Operand clamp to the internal word.
	logic [TOP_W-1:0] in_top;
	logic             in_fits;
	logic [W-1:0]     x_in;

	// Magnitudes for the multiply or divide of the pending term by the operand.
	logic [W-1:0] t_u, x_u, mag_a, mag_b;

	// Shared adder connections.
	logic [AW-1:0] add_a, add_b, add_sum;
	logic          add_sub;

	logic         nbit;
	logic [W-1:0] div_shift;
	logic         ge;

	logic [XW-1:0] px, tx;
	logic          rbit, hi_nz;
	logic [AW-1:0] lim, mag;
	logic          sat;
	logic [W-1:0]  pres;

	logic          ovf;
	logic [W-1:0]  sum_new;
	logic [1:0]    sum_op_new;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = ctrl.idle;

	assign in_top  = operand_value[ipe_pkg::DATA_BITS-1:W-1];
	assign in_fits = (&in_top) || (~|in_top);
	assign x_in    = in_fits ? operand_value[W-1:0]
		: (operand_value[ipe_pkg::DATA_BITS-1] ? WMIN : WMAX);

	assign status.accept    = accept;
	assign status.pending   = pending_q;
	assign status.divides   = divides_q;
	assign status.div_zero  = (x_q == '0);
	assign status.last      = last_q;
	assign status.hold_term = !last_q && (op_q == ipe_pkg::OP_MUL || op_q == ipe_pkg::OP_DIV);
	assign status.out_free  = out_free;

	ipe_seq #(
		.WORD_BITS     (WORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	ipe_addsub #(
		.WIDTH (AW)
	) u_addsub (
		.a   (add_a),
		.b   (add_b),
		.sub (add_sub),
		.sum (add_sum)
	);

	always_comb begin
		t_u   = term_q;
		x_u   = x_q;
		mag_a = t_u[W-1] ? (~t_u + W'(1)) : t_u;
		mag_b = x_u[W-1] ? (~x_u + W'(1)) : x_u;

		// A divide step brings down the next numerator bit; the rounding step
		// brings down a zero, which compares twice the remainder with the divisor.
		nbit      = ctrl.div_step ? sh_q[N-1] : 1'b0;
		div_shift = {acc_q[W-2:0], nbit};

		// Unpack: the product drops its fraction bits and rounds on the highest
		// dropped bit; the quotient already carries its rounding bit.
		px    = XW'({acc_q, sh_q[W-1:0]});
		tx    = divides_q ? XW'(sh_q) : (px >> F);
		rbit  = divides_q ? rb_q : (RB_EN && px[RB_IDX]);
		hi_nz = |tx[XW-1:W];
		lim   = {1'b0, neg_q, {(W - 1){!neg_q}}};

		// The adder is used by exactly one step at a time.
		if (ctrl.mul_step) begin
			add_a   = {1'b0, acc_q};
			add_b   = sh_q[0] ? {1'b0, ma_q} : '0;
			add_sub = 1'b0;
		end else if (ctrl.div_step || ctrl.rnd_step) begin
			add_a   = {1'b0, div_shift};
			add_b   = {1'b0, ma_q};
			add_sub = 1'b1;
		end else if (ctrl.pack) begin
			add_a   = {1'b0, tx[W-1:0]};
			add_b   = AW'(rbit);
			add_sub = 1'b0;
		end else begin
			add_a   = {sum_q[W-1], sum_q};
			add_b   = {tres_q[W-1], tres_q};
			add_sub = (sum_op_q == ipe_pkg::SUM_SUB);
		end

		// A trial subtract that stays non-negative yields a quotient one.
		ge = !add_sum[W];

		// Saturate the rounded magnitude to the bound for its sign, then apply the sign.
		sat  = hi_nz || (add_sum > lim);
		mag  = sat ? lim : add_sum;
		pres = neg_q ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];

		// Running sum: exact in W+1 bits, saturated when the top two bits differ.
		ovf     = add_sum[W] ^ add_sum[W-1];
		sum_new = ovf ? (add_sum[W] ? WMIN : WMAX) : add_sum[W-1:0];

		if (op_q == ipe_pkg::OP_ADD) sum_op_new = ipe_pkg::SUM_ADD;
		else if (op_q == ipe_pkg::OP_SUB) sum_op_new = ipe_pkg::SUM_SUB;
		else sum_op_new = ipe_pkg::SUM_DROP;
	end

	// Expression state and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			sum_op_q    <= ipe_pkg::SUM_ADD;
			started_q   <= 1'b0;
			term_q      <= '0;
			pending_q   <= 1'b0;
			divides_q   <= 1'b0;
			err_q       <= ipe_pkg::ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				// A first item drops whatever expression was in progress.
				if (first_item) begin
					sum_q     <= '0;
					sum_op_q  <= ipe_pkg::SUM_ADD;
					started_q <= 1'b0;
					term_q    <= '0;
					pending_q <= 1'b0;
					divides_q <= 1'b0;
				end
				err_q <= ipe_pkg::err_max(first_item ? ipe_pkg::ERR_NONE : err_q,
					in_fits ? ipe_pkg::ERR_NONE : ipe_pkg::ERR_OVF);
			end

			if (ctrl.prep && pending_q && divides_q && status.div_zero)
				err_q <= ipe_pkg::err_max(err_q, ipe_pkg::ERR_DIV0);

			if (ctrl.pack && sat)
				err_q <= ipe_pkg::err_max(err_q, ipe_pkg::ERR_OVF);

			if (ctrl.comb) begin
				if (status.hold_term) begin
					// The term waits for another factor.
					term_q    <= tres_q;
					pending_q <= 1'b1;
					divides_q <= (op_q == ipe_pkg::OP_DIV);
				end else begin
					// The term closes: fold it into the sum, except after an
					// unknown operator, which drops it.
					if (!started_q) begin
						sum_q <= tres_q;
					end else if (sum_op_q == ipe_pkg::SUM_ADD || sum_op_q == ipe_pkg::SUM_SUB) begin
						sum_q <= sum_new;
						if (ovf) err_q <= ipe_pkg::err_max(err_q, ipe_pkg::ERR_OVF);
					end
					started_q <= 1'b1;
					sum_op_q  <= sum_op_new;
					term_q    <= '0;
					pending_q <= 1'b0;
					divides_q <= 1'b0;
				end
			end

			if (ctrl.emit && out_free) begin
				// The result leaves; the next item starts a fresh expression.
				sum_q       <= '0;
				sum_op_q    <= ipe_pkg::SUM_ADD;
				started_q   <= 1'b0;
				term_q      <= '0;
				pending_q   <= 1'b0;
				divides_q   <= 1'b0;
				err_q       <= ipe_pkg::ERR_NONE;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, iteration registers and the output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= x_in;
			op_q   <= operator_code;
			last_q <= last_item;
		end

		if (ctrl.prep) begin
			neg_q <= term_q[W-1] ^ x_q[W-1];
			acc_q <= '0;
			if (divides_q) begin
				ma_q <= mag_b;
				sh_q <= N'(mag_a) << F;
			end else begin
				ma_q <= mag_a;
				sh_q <= N'(mag_b);
			end
			// Without a pending factor the operand is the term. A zero divisor
			// saturates toward the sign of the dividend.
			if (!pending_q) tres_q <= x_q;
			else tres_q <= term_q[W-1] ? WMIN : WMAX;
		end

		if (ctrl.mul_step) begin
			acc_q         <= add_sum[W:1];
			sh_q[W-1:0]   <= {add_sum[0], sh_q[W-1:1]};
		end

		if (ctrl.div_step) begin
			acc_q <= ge ? add_sum[W-1:0] : div_shift;
			sh_q  <= {sh_q[N-2:0], ge};
		end

		if (ctrl.rnd_step) rb_q <= ge;

		if (ctrl.pack) tres_q <= pres;

		if (ctrl.emit && out_free) begin
			result_q  <= ipe_pkg::DATA_BITS'(sum_q);
			err_out_q <= err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign error_code   = err_out_q;

endmodule
